@@ design/md5_pkg.sv @@
// shared constants, codes, round tables and control types for the md5 digest block
package md5_pkg;

    // initial chaining words
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    // padding marker and start of the length field within a block
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // block kinds: how each byte of the block being compressed is formed
    localparam logic [1:0] KIND_FULL = 2'd0;  // all bytes from the store
    localparam logic [1:0] KIND_PAD  = 2'd1;  // stored bytes, marker, zeros, length if room
    localparam logic [1:0] KIND_LEN  = 2'd2;  // zeros then the length

    // block store control from the sequencer
    typedef struct packed {
        logic       rd_en;
        logic [3:0] word_idx;
        logic [1:0] kind;
    } t_store_ctrl;

    // additive constant of round i
    function automatic logic [31:0] f_round_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // left rotate amount of round i, never zero
    function automatic logic [4:0] f_rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // message word used by round i
    function automatic logic [3:0] f_word_index(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0:    g = i[3:0];
            2'd1:    g = 4'((i[3:0] << 2) + i[3:0] + 4'd1);
            2'd2:    g = 4'((i[3:0] << 1) + i[3:0] + 4'd5);
            default: g = 4'((i[3:0] << 3) - i[3:0]);
        endcase
        return g;
    endfunction

endpackage

@@ design/md5_message_digest.sv @@
// md5 digest top level: byte intake, round sequencer, chaining words and digest output
//
// Each request carries at most one message byte; a byte that does not fill the
// 64-byte block is taken without a stall. The byte that fills a block, and a request
// that ends the message, start a compression (one store read ahead of the rounds,
// 64 rounds through a single shared round unit, one add into the chaining
// words), during which o_in_stall is high. Ending a message costs one
// compression, or two when the message length modulo 64 is 56 or more, followed by
// four digest words, word 0 first, each held until taken. After the fourth word the
// chaining words, byte position and bit count return to their initial values.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_ends_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_number,
    output logic        o_last_word
);
    import md5_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [5:0]  r_round, n_round;
    logic [1:0]  r_kind, n_kind;
    logic        r_finish, n_finish;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_bit_len, n_bit_len;
    logic [1:0]  r_word, n_word;
    logic [31:0] r_h [0:3];
    logic [31:0] n_h [0:3];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_wr_en;
    logic [5:0]  w_pos_inc;
    logic [5:0]  w_rd_round;
    t_store_ctrl w_ctrl;
    logic [31:0] w_word;
    logic [31:0] w_ra, w_rb, w_rc, w_rd;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_OUT);
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_wr_en     = w_in_acc && i_byte_present;
    assign w_pos_inc   = r_pos + 6'd1;

    // store read runs one round ahead of the round unit
    assign w_rd_round      = (r_state == S_FETCH) ? 6'd0 : (r_round + 6'd1);
    assign w_ctrl.rd_en    = (r_state == S_FETCH) || (r_state == S_ROUND);
    assign w_ctrl.word_idx = f_word_index(w_rd_round);
    assign w_ctrl.kind     = r_kind;

    md5_block_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_pos),
        .i_wr_byte (i_data_byte),
        .i_ctrl    (w_ctrl),
        .i_pos     (r_pos),
        .i_bit_len (r_bit_len),
        .o_word    (w_word)
    );

    md5_round u_round (
        .i_round (r_round),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .i_word  (w_word),
        .o_a     (w_ra),
        .o_b     (w_rb),
        .o_c     (w_rc),
        .o_d     (w_rd)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_kind    = r_kind;
        n_finish  = r_finish;
        n_pos     = r_pos;
        n_bit_len = r_bit_len;
        n_word    = r_word;
        n_h       = r_h;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_finish = i_ends_message;
                    if (i_byte_present) begin
                        n_pos     = w_pos_inc;
                        n_bit_len = r_bit_len + 64'd8;
                    end
                    if (i_byte_present && w_pos_inc == 6'd0) begin
                        n_kind  = KIND_FULL;
                        n_state = S_FETCH;
                    end else if (i_ends_message) begin
                        n_kind  = KIND_PAD;
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                n_a     = r_h[0];
                n_b     = r_h[1];
                n_c     = r_h[2];
                n_d     = r_h[3];
                n_round = 6'd0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_a     = w_ra;
                n_b     = w_rb;
                n_c     = w_rc;
                n_d     = w_rd;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_h[0] = r_h[0] + r_a;
                n_h[1] = r_h[1] + r_b;
                n_h[2] = r_h[2] + r_c;
                n_h[3] = r_h[3] + r_d;
                n_word = 2'd0;
                if (r_kind == KIND_FULL) begin
                    n_kind  = KIND_PAD;
                    n_state = r_finish ? S_FETCH : S_IDLE;
                end else if (r_kind == KIND_PAD && r_pos >= LEN_OFFSET) begin
                    n_kind  = KIND_LEN;
                    n_state = S_FETCH;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_word = r_word + 2'd1;
                    if (r_word == 2'd3) begin
                        n_h[0]    = IV_A;
                        n_h[1]    = IV_B;
                        n_h[2]    = IV_C;
                        n_h[3]    = IV_D;
                        n_pos     = 6'd0;
                        n_bit_len = 64'd0;
                        n_finish  = 1'b0;
                        n_state   = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and chaining registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= 6'd0;
            r_kind    <= KIND_FULL;
            r_finish  <= 1'b0;
            r_pos     <= 6'd0;
            r_bit_len <= 64'd0;
            r_word    <= 2'd0;
            r_h[0]    <= IV_A;
            r_h[1]    <= IV_B;
            r_h[2]    <= IV_C;
            r_h[3]    <= IV_D;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_kind    <= n_kind;
            r_finish  <= n_finish;
            r_pos     <= n_pos;
            r_bit_len <= n_bit_len;
            r_word    <= n_word;
            r_h       <= n_h;
        end
    end

    // working variables of the compression
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
    end

    // digest output
    assign o_digest_word = r_h[r_word];
    assign o_word_number = r_word;
    assign o_last_word   = (r_word == 2'd3);

endmodule

@@ design/md5_round.sv @@
// one md5 round step, shared by all 64 rounds of a compression
module md5_round (
    input  logic [5:0]  i_round,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [31:0] i_word,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);
    import md5_pkg::*;

    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [4:0]  w_rot;
    logic [31:0] w_rotated;

    // boolean function of the current phase
    always_comb begin
        case (i_round[5:4])
            2'd0:    w_f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    w_f = (i_b & i_d) | (i_c & ~i_d);
            2'd2:    w_f = i_b ^ i_c ^ i_d;
            default: w_f = i_c ^ (i_b | ~i_d);
        endcase
    end

    // sum, rotate and shuffle
    assign w_sum     = w_f + i_a + f_round_const(i_round) + i_word;
    assign w_rot     = f_rot_amount(i_round);
    assign w_rotated = (w_sum << w_rot) | (w_sum >> (6'd32 - {1'b0, w_rot}));

    assign o_a = i_d;
    assign o_d = i_c;
    assign o_c = i_b;
    assign o_b = i_b + w_rotated;

endmodule

@@ design/md5_block_store.sv @@
// 64-byte block store in four byte lanes, with padding and length inserted on read
module md5_block_store (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [5:0]           i_wr_addr,
    input  logic [7:0]           i_wr_byte,
    input  md5_pkg::t_store_ctrl i_ctrl,
    input  logic [5:0]           i_pos,
    input  logic [63:0]          i_bit_len,
    output logic [31:0]          o_word
);
    import md5_pkg::*;

    logic [3:0] r_word_idx;
    logic [1:0] r_kind;

    // word index and kind travel with the registered read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_word_idx <= i_ctrl.word_idx;
            r_kind     <= i_ctrl.kind;
        end
    end

    for (genvar lane = 0; lane < 4; lane++) begin : g_lane
        logic [7:0] r_mem [0:15];
        logic [7:0] r_rd_byte;
        logic [5:0] w_byte_pos;
        logic       w_len_here;
        logic [7:0] w_byte;

        // lane memory, one write and one registered read
        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_addr[1:0] == 2'(lane))) begin
                r_mem[i_wr_addr[5:2]] <= i_wr_byte;
            end
            if (i_ctrl.rd_en) begin
                r_rd_byte <= r_mem[i_ctrl.word_idx];
            end
        end

        // byte formation for the padded tail of a message
        assign w_byte_pos = {r_word_idx, 2'(lane)};
        assign w_len_here = (w_byte_pos >= LEN_OFFSET)
                          && ((r_kind == KIND_LEN)
                              || ((r_kind == KIND_PAD) && (i_pos < LEN_OFFSET)));

        // the length-only block keeps nothing from the store
        always_comb begin
            if (r_kind == KIND_FULL || (r_kind == KIND_PAD && w_byte_pos < i_pos)) begin
                w_byte = r_rd_byte;
            end else if (r_kind == KIND_PAD && w_byte_pos == i_pos) begin
                w_byte = PAD_MARK;
            end else if (w_len_here) begin
                w_byte = i_bit_len[{w_byte_pos[2:0], 3'b000} +: 8];
            end else begin
                w_byte = 8'h00;
            end
        end

        assign o_word[8*lane +: 8] = w_byte;
    end

endmodule

@@ test/tb_md5_message_digest.sv @@
// self-checking testbench for md5_message_digest: directed table, random messages, digest scoreboard
`timescale 1ns / 100ps

module tb_md5_message_digest;

    // one digest word as it leaves the block
    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  num;
        logic        last;
    } t_digest_word;

    // one row of the directed table; digest word i sits at bits [32*i +: 32]
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         ends;
        logic         typed;
        logic [127:0] digest;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 18;
    localparam int RANDOM_ITEMS  = 300;
    localparam int MIN_MESSAGES  = 12;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [127:0] EMPTY_DIGEST = 128'h7e42f8ec_980980e9_04b2008f_d98c1dd4;
    localparam logic [127:0] ABC_DIGEST   = 128'h727fe128_7d3f96d6_b04fd23c_98500190;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_ends_message;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_digest_word;
    logic [1:0]  o_word_number;
    logic        o_last_word;

    md5_message_digest uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_ends_message (i_ends_message),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digest_word  (o_digest_word),
        .o_word_number  (o_word_number),
        .o_last_word    (o_last_word)
    );

    // clock, 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // round additive constants and rotate amounts
    logic [31:0] sine_table [0:63] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    int rot_table [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    // directed stimulus: special cases first, then field extremes
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message
        '{8'ha5, 1'b0, 1'b0, 1'b0, 128'h0},        // empty step
        '{8'hff, 1'b0, 1'b0, 1'b0, 128'h0},        // byte ignored
        '{8'h61, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 128'h0},
        '{8'h62, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},    // byte absorbed before finishing
        '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // finish ignores data_byte
        '{8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'hff, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 128'h0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 128'h0},
        '{8'hff, 1'b1, 1'b1, 1'b0, 128'h0},
        '{8'h80, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h7f, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'h01, 1'b1, 1'b0, 1'b0, 128'h0},
        '{8'hfe, 1'b1, 1'b1, 1'b0, 128'h0}
    };

    // predictor state
    logic [31:0] chain [0:3];
    logic [7:0]  block_store [0:63];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;

    t_digest_word words_due [$];

    // request currently offered, with its typed digest if any
    logic         cur_typed;
    logic [127:0] cur_typed_digest;

    int  failures       = 0;
    int  words_checked  = 0;
    int  msgs_done      = 0;
    int  bytes_taken    = 0;
    int  two_block_ends = 0;
    int  burst_left     = 0;
    logic hold_req      = 1'b0;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // 64 rounds over the block store, added into the chaining words
    task automatic md5_compress();
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, f;
        int          i, g, ph;
        for (i = 0; i < 16; i++)
            w[i] = {block_store[4*i+3], block_store[4*i+2], block_store[4*i+1], block_store[4*i]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (i = 0; i < 64; i++) begin
            ph = i / 16;
            case (ph)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            f = f + a + sine_table[i] + w[g];
            a = d;
            d = c;
            c = b;
            b = b + rotl(f, rot_table[ph * 4 + i % 4]);
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
    endtask

    task automatic md5_restart();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        fill_pos = '0;
        msg_bits = '0;
    endtask

    // absorb one request; on a finish return the digest and restart
    task automatic md5_take_request(input logic [7:0] b, input logic p, input logic e,
                                    output logic done, output logic [127:0] digest);
        int i;
        done   = 1'b0;
        digest = '0;
        if (p) begin
            block_store[fill_pos] = b;
            msg_bits              = msg_bits + 64'd8;
            fill_pos              = fill_pos + 6'd1;
            bytes_taken++;
            if (fill_pos == 6'd0)
                md5_compress();
        end
        if (e) begin
            block_store[fill_pos] = 8'h80;
            for (i = fill_pos + 1; i < 64; i++)
                block_store[i] = 8'h00;
            if (fill_pos >= 6'd56) begin
                md5_compress();
                for (i = 0; i < 64; i++)
                    block_store[i] = 8'h00;
                two_block_ends++;
            end
            for (i = 0; i < 8; i++)
                block_store[56 + i] = msg_bits[8*i +: 8];
            md5_compress();
            digest = {chain[3], chain[2], chain[1], chain[0]};
            done   = 1'b1;
            msgs_done++;
            md5_restart();
        end
    endtask

    task automatic note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // sender: bursts of requests with random gaps, each held until taken
    task automatic offer_request(input logic [7:0] b, input logic p, input logic e,
                                 input logic typed, input logic [127:0] digest);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        cur_typed        = typed;
        cur_typed_digest = digest;
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= p;
        i_ends_message <= e;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left--;
        @(negedge i_clk);
    endtask

    // predict on every accepted request
    always @(posedge i_clk) begin : intake_monitor
        logic         done;
        logic [127:0] digest;
        int           k;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            md5_take_request(i_data_byte, i_byte_present, i_ends_message, done, digest);
            if (done) begin
                if (cur_typed)
                    digest = cur_typed_digest;
                for (k = 0; k < 4; k++)
                    words_due.push_back('{digest[32*k +: 32], 2'(k), k == 3});
            end
        end
    end

    // compare each accepted digest word with the oldest expectation
    always @(posedge i_clk) begin : digest_checker
        t_digest_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_checked++;
            if (words_due.size() == 0) begin
                note_failure($sformatf("unexpected digest word %h", o_digest_word));
            end else begin
                want = words_due.pop_front();
                if (o_digest_word !== want.word || o_word_number !== want.num
                        || o_last_word !== want.last)
                    note_failure($sformatf("digest word: expected %h num %0d last %b, got %h num %0d last %b",
                                           want.word, want.num, want.last,
                                           o_digest_word, o_word_number, o_last_word));
            end
        end
    end

    // receiver: stall patterns in runs, plus one long hold-off
    initial begin : result_stall
        int   run, mode, r;
        logic did_hold;
        did_hold    = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            if (hold_req && !did_hold) begin
                did_hold = 1'b1;
                for (r = 0; r < HOLD_CYCLES; r++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 40);
            for (r = 0; r < run; r++) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= 1'($urandom_range(0, 1));
                    2:       i_out_stall <= (r % 3 == 0);
                    default: i_out_stall <= (r < 20);
                endcase
            end
        end
    end

    // run limit
    initial begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // main sequence
    initial begin
        int row, len, k, sel, items, msgs, wait_cycles;
        logic [7:0] b;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_data_byte    = 8'h00;
        i_byte_present = 1'b0;
        i_ends_message = 1'b0;
        cur_typed      = 1'b0;
        cur_typed_digest = '0;
        for (k = 0; k < 64; k++)
            block_store[k] = 8'h00;
        md5_restart();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_request(directed_rows[row].data, directed_rows[row].present,
                          directed_rows[row].ends, directed_rows[row].typed,
                          directed_rows[row].digest);

        // random messages, mostly short, some around the padding boundaries
        hold_req = 1'b1;
        items = 0;
        msgs  = 0;
        while (items < RANDOM_ITEMS || msgs < MIN_MESSAGES) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                len = $urandom_range(0, 12);
            end else begin
                case ($urandom_range(0, 7))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    default: len = 120;
                endcase
            end
            sel = $urandom_range(0, 1);
            for (k = 0; k < len; k++) begin
                // occasional empty step between bytes
                if ($urandom_range(0, 9) == 0)
                    offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
                b = 8'($urandom_range(0, 255));
                offer_request(b, 1'b1, (k == len - 1) && sel == 1, 1'b0, '0);
                items++;
            end
            if (len == 0 || sel == 0) begin
                offer_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
                items++;
            end
            msgs++;
        end
        i_in_valid <= 1'b0;

        // drain and let the block settle
        wait_cycles = 0;
        while (words_due.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (150) @(posedge i_clk);
        if (words_due.size() != 0)
            note_failure($sformatf("%0d digest words never arrived", words_due.size()));

        $display("covered %0d messages, %0d bytes, %0d needing a second padding block",
                 msgs_done, bytes_taken, two_block_ends);
        $display("compared %0d digest words, %0d failures", words_checked, failures);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
